@@ src/phg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_pkg
// shared constants, types and hash function for the per-host gap gate
// ----------------------------------------------------------------------------
package phg_pkg;
	localparam int SLOTS = 1024;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int KEY_W = 64;
	localparam int TIME_W = 40;
	localparam int CNT_W = 32;
	localparam int ACT_W = 16;
	localparam logic [ACT_W-1:0] ACTIVE_MAX = '1;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	typedef enum logic [2:0] {
		ST_GRANTED = 3'd0,
		ST_WAIT = 3'd1,
		ST_TIMEOUT = 3'd2,
		ST_UNGATED = 3'd3,
		ST_RELEASED = 3'd4
	} status_t;

	localparam logic REQ_ACQUIRE = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	localparam logic REG_MAX_CONC = 1'b0;
	localparam logic REG_MIN_GAP = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load;
		logic hash_step;
		logic probe_rd;
		logic probe_next;
		logic eval;
		logic commit;
		logic ungated;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic hash_done;
		logic hit;
		logic free_slot;
		logic probe_last;
		logic bypass;
		logic out_full;
	} stat_t;

	// one fnv-1a byte step: xor the byte in, then multiply by the prime
	function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_PRIME;
	endfunction
endpackage

@@ src/phg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_req_if / phg_rsp_if
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface phg_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [63:0] host_key;
	logic [39:0] now_ms;
	logic [39:0] deadline_ms;
	logic is_retry;
	modport source(output valid, req_type, host_key, now_ms, deadline_ms, is_retry,
		input ready);
	modport sink(input valid, req_type, host_key, now_ms, deadline_ms, is_retry,
		output ready);
endinterface

interface phg_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [39:0] wake_ms;
	logic [31:0] waits_total;
	logic [31:0] timeouts_total;
	logic [31:0] inflight_total;
	modport source(output valid, status, wake_ms, waits_total, timeouts_total,
		inflight_total, input ready);
	modport sink(input valid, status, wake_ms, waits_total, timeouts_total,
		inflight_total, output ready);
endinterface

@@ src/per_host_concurrency_gap_gate_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_host_concurrency_gap_gate_unit
// per-host in-flight limiter with minimum grant gap over a hashed slot table
// ----------------------------------------------------------------------------
// channel | dir | contents
// req     | in  | req_type, host_key, now_ms, deadline_ms, is_retry
// rsp     | out | status, wake_ms, waits_total, timeouts_total, inflight_total
// apb     | in  | max_concurrent (0x0), min_gap_ms (0x4)
//
// after reset a clearing pass wipes all 1024 slots of the table, req.ready low
// a request runs the byte-serial fnv hash over the eight key bytes, then
// reads and checks one slot of the memory per probe, then evaluates and
// writes back before the result register is loaded
// a gated-off acquire skips the probe walk and answers from the hash state
// a new request waits while the result register is still full
module per_host_concurrency_gap_gate_unit (
	input  logic clk,
	input  logic arst_n,
	phg_req_if.sink req,
	phg_rsp_if.source rsp,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import phg_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic [7:0] max_conc_q;
	logic [15:0] min_gap_q;
	logic in_ready;

	assign pready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_conc_q <= 8'd2;
			min_gap_q <= 16'd150;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			case (paddr[2])
				REG_MAX_CONC: max_conc_q <= pwdata[7:0];
				REG_MIN_GAP: min_gap_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_CONC: prdata = {24'd0, max_conc_q};
			REG_MIN_GAP: prdata = {16'd0, min_gap_q};
			default: prdata = '0;
		endcase
	end

	phg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	phg_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_ready(in_ready),
		.max_concurrent(max_conc_q), .min_gap_ms(min_gap_q), .req(req), .rsp(rsp)
	);
endmodule

@@ src/phg_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_ctrl
// sequencer: table clear, hash, probe walk, evaluate, commit, result handoff
// ----------------------------------------------------------------------------
module phg_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  phg_pkg::stat_t stat,
	output phg_pkg::cmd_t cmd
);
	import phg_pkg::*;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_HASH, S_RD, S_CHK, S_EVAL, S_PUSH
	} state_t;
	state_t state_q;

	assign in_ready = (state_q == S_IDLE) && !stat.out_full;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.clear = (state_q == S_CLR);
		cmd.load = in_valid && in_ready;
		cmd.hash_step = (state_q == S_HASH);
		cmd.probe_rd = (state_q == S_RD);
		cmd.probe_next = (state_q == S_CHK) && !stat.hit && !stat.free_slot
			&& !stat.probe_last;
		cmd.eval = (state_q == S_EVAL);
		cmd.commit = (state_q == S_PUSH);
		cmd.ungated = (state_q == S_CHK) && !stat.hit && !stat.free_slot
			&& stat.probe_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			case (state_q)
				S_CLR: if (stat.clear_done) state_q <= S_IDLE;
				S_IDLE: if (cmd.load) state_q <= S_HASH;
				S_HASH: begin
					if (stat.bypass) state_q <= S_IDLE;
					else if (stat.hash_done) state_q <= S_RD;
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (stat.hit || stat.free_slot) state_q <= S_EVAL;
					else if (stat.probe_last) state_q <= S_IDLE;
					else state_q <= S_RD;
				end
				S_EVAL: state_q <= S_PUSH;
				S_PUSH: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ src/phg_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_dp
// hash unit, slot table memory, gate evaluation, totals and output register
// ----------------------------------------------------------------------------
module phg_dp (
	input  logic clk,
	input  logic arst_n,
	input  phg_pkg::cmd_t cmd,
	output phg_pkg::stat_t stat,
	input  logic in_ready,
	input  logic [7:0] max_concurrent,
	input  logic [15:0] min_gap_ms,
	phg_req_if.sink req,
	phg_rsp_if.source rsp
);
	import phg_pkg::*;

	// entry: used bit, key, active count, last grant
	localparam int ENT_W = 1 + KEY_W + ACT_W + TIME_W;

	// request latch
	logic rtype_q, retry_q;
	logic [KEY_W-1:0] key_q;
	logic [TIME_W-1:0] now_q, dl_q;
	logic [31:0] hash_q;
	logic [3:0] hstep_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W:0] probes_q;
	logic [IDX_W-1:0] clr_q;

	// slot table with the used bit kept in each entry
	logic [ENT_W-1:0] mem [SLOTS];
	logic [ENT_W-1:0] rd_q;
	logic used_rd;

	logic [KEY_W-1:0] e_key;
	logic [ACT_W-1:0] e_act;
	logic [TIME_W-1:0] e_last;
	assign used_rd = rd_q[ENT_W-1];
	assign e_key = rd_q[ENT_W-2 -: KEY_W];
	// fresh slot reads as zero
	assign e_act = used_rd ? rd_q[TIME_W +: ACT_W] : '0;
	assign e_last = used_rd ? rd_q[TIME_W-1:0] : '0;

	logic [CNT_W-1:0] waits_q, tmo_q, act_q;
	logic out_v_q;
	status_t st_q;
	logic [TIME_W-1:0] wake_q;

	// evaluation stage
	logic grant_s1, tmo_s1;
	logic [ACT_W-1:0] nact_s1;
	logic dec_s1;
	status_t st_s1;
	logic [TIME_W-1:0] wake_s1;

	logic bypass;
	assign bypass = (rtype_q == REQ_ACQUIRE) && max_concurrent == 8'd0
		&& min_gap_ms == 16'd0;

	assign stat.clear_done = clr_q == IDX_W'(SLOTS - 1);
	assign stat.hash_done = hstep_q == 4'd8;
	assign stat.hit = used_rd && e_key == key_q;
	assign stat.free_slot = !used_rd;
	assign stat.probe_last = probes_q == (IDX_W+1)'(SLOTS - 1);
	assign stat.bypass = bypass;
	assign stat.out_full = out_v_q;
	assign req.ready = in_ready;

	// clearing pass address after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// request capture, hash and probe index
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rtype_q <= req.req_type;
			key_q <= req.host_key;
			now_q <= req.now_ms;
			dl_q <= req.deadline_ms;
			retry_q <= req.is_retry;
			hash_q <= FNV_BASIS;
			hstep_q <= '0;
			probes_q <= '0;
		end else if (cmd.hash_step && !stat.hash_done) begin
			hash_q <= fnv_step(hash_q, key_q[8*hstep_q[2:0] +: 8]);
			hstep_q <= hstep_q + 4'd1;
		end else if (cmd.hash_step) begin
			idx_q <= hash_q[IDX_W-1:0];
		end else if (cmd.probe_next) begin
			idx_q <= idx_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
	end

	// table read port
	always_ff @(posedge clk) begin
		if (cmd.probe_rd)
			rd_q <= mem[idx_q];
	end

	// gate decision
	logic [TIME_W:0] gap_end;
	logic conc_ok, gap_ok;
	assign gap_end = {1'b0, e_last} + {{(TIME_W-15){1'b0}}, min_gap_ms};
	assign conc_ok = e_act != ACTIVE_MAX
		&& (max_concurrent == 8'd0 || e_act < {8'd0, max_concurrent});
	assign gap_ok = min_gap_ms == 16'd0 || {1'b0, now_q} >= gap_end;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			grant_s1 <= 1'b0;
			tmo_s1 <= 1'b0;
			dec_s1 <= 1'b0;
			nact_s1 <= e_act;
			wake_s1 <= '0;
			if (rtype_q == REQ_RELEASE) begin
				st_s1 <= ST_RELEASED;
				if (e_act != '0) begin
					dec_s1 <= 1'b1;
					nact_s1 <= e_act - 1'b1;
				end
			end else if (conc_ok && gap_ok) begin
				st_s1 <= ST_GRANTED;
				grant_s1 <= 1'b1;
				nact_s1 <= e_act + 1'b1;
			end else if (now_q >= dl_q) begin
				st_s1 <= ST_TIMEOUT;
				tmo_s1 <= 1'b1;
			end else begin
				st_s1 <= ST_WAIT;
				wake_s1 <= (!gap_ok && gap_end < {1'b0, dl_q})
					? gap_end[TIME_W-1:0] : dl_q;
			end
		end
	end

	// table write: clearing pass, then commits
	always_ff @(posedge clk) begin
		if (cmd.clear)
			mem[clr_q] <= '0;
		else if (cmd.commit)
			mem[idx_q] <= {1'b1, key_q, nact_s1, grant_s1 ? now_q : e_last};
	end

	// totals, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waits_q <= '0;
			tmo_q <= '0;
			act_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && rsp.ready) out_v_q <= 1'b0;
			if (cmd.commit) begin
				if (grant_s1) begin
					act_q <= act_q + 1'b1;
					if (retry_q) waits_q <= waits_q + 1'b1;
				end
				if (dec_s1) act_q <= act_q - 1'b1;
				if (tmo_s1) tmo_q <= tmo_q + 1'b1;
				out_v_q <= 1'b1;
			end else if (cmd.ungated || (cmd.hash_step && bypass)) begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			st_q <= st_s1;
			wake_q <= wake_s1;
		end else if (cmd.ungated || (cmd.hash_step && bypass)) begin
			st_q <= (rtype_q == REQ_RELEASE) ? ST_RELEASED : ST_UNGATED;
			wake_q <= '0;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = st_q;
	assign rsp.wake_ms = wake_q;
	assign rsp.waits_total = waits_q;
	assign rsp.timeouts_total = tmo_q;
	assign rsp.inflight_total = act_q;
endmodule

@@ src/phg_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_checker
// port-level checks on request and result sequencing
// ----------------------------------------------------------------------------
module phg_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] rsp_status,
	input logic [39:0] rsp_wake_ms
);
	import phg_pkg::*;

	// no new request while a result is pending
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready) else $error("request taken while result pending");

	// accepted request blocks further requests next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready) else $error("ready after accept");

	// wake is zero except for wait
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status != ST_WAIT) |-> rsp_wake_ms == '0)
		else $error("wake set outside wait");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_status))
		else $error("result dropped");
endmodule

bind per_host_concurrency_gap_gate_unit phg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
	.rsp_wake_ms(rsp.wake_ms)
);

@@ sim/phg_gate_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phg_gate_checker
// Watches the request, result and register ports of the per-host gap gate.
// Keeps its own copy of the slot table, counters and settings, works out the
// result of every accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module phg_gate_checker
	import phg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	phg_req_if req_mon,
	phg_rsp_if rsp_mon,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	output int errors,
	output int pending,
	output int granted_seen,
	output int waited_seen,
	output int timeout_seen,
	output int ungated_seen
);
	typedef struct {
		status_t status;
		logic [TIME_W-1:0] wake;
		logic [CNT_W-1:0] waits;
		logic [CNT_W-1:0] timeouts;
		logic [CNT_W-1:0] inflight;
	} gate_result_t;

	// local copy of the gate state
	logic [7:0] conc_limit;
	logic [15:0] gap_ms;
	bit slot_taken [SLOTS];
	logic [KEY_W-1:0] slot_key [SLOTS];
	logic [ACT_W-1:0] slot_busy [SLOTS];
	logic [TIME_W-1:0] slot_granted_at [SLOTS];
	logic [CNT_W-1:0] wait_cnt, timeout_cnt, inflight_cnt;

	gate_result_t expected_results [$];

	function automatic logic [31:0] host_hash(logic [63:0] key);
		logic [31:0] h;
		h = FNV_BASIS;
		for (int b = 0; b < 8; b++) begin
			h = (h ^ {24'd0, key[8*b +: 8]}) * FNV_PRIME;
		end
		return h;
	endfunction

	// linear probe, claiming the first free slot; -1 when the table is full and the key absent
	task automatic lookup_host(input logic [63:0] key, output int slot);
		int start;
		int idx;
		start = int'(host_hash(key) % SLOTS);
		slot = -1;
		for (int i = 0; i < SLOTS; i++) begin
			idx = (start + i) % SLOTS;
			if (!slot_taken[idx]) begin
				slot_taken[idx] = 1'b1;
				slot_key[idx] = key;
				slot_busy[idx] = '0;
				slot_granted_at[idx] = '0;
				slot = idx;
				break;
			end
			if (slot_key[idx] == key) begin
				slot = idx;
				break;
			end
		end
	endtask

	task automatic predict_gate(input logic rtype, input logic [63:0] key,
		input logic [39:0] now, input logic [39:0] deadline, input logic retry,
		output gate_result_t r);
		int s;
		logic [40:0] gap_end;
		bit conc_ok, gap_ok;
		r.status = ST_RELEASED;
		r.wake = '0;
		if (rtype == REQ_RELEASE) begin
			lookup_host(key, s);
			if (s >= 0 && slot_busy[s] != '0) begin
				slot_busy[s]--;
				inflight_cnt--;
			end
		end else if (conc_limit == 0 && gap_ms == 0) begin
			r.status = ST_UNGATED;
		end else begin
			lookup_host(key, s);
			if (s < 0) begin
				r.status = ST_UNGATED;
			end else begin
				gap_end = {1'b0, slot_granted_at[s]} + 41'(gap_ms);
				conc_ok = slot_busy[s] != ACTIVE_MAX &&
					(conc_limit == 0 || slot_busy[s] < ACT_W'(conc_limit));
				gap_ok = gap_ms == 0 || {1'b0, now} >= gap_end;
				if (conc_ok && gap_ok) begin
					slot_busy[s]++;
					slot_granted_at[s] = now;
					inflight_cnt++;
					if (retry) wait_cnt++;
					r.status = ST_GRANTED;
				end else if (now >= deadline) begin
					timeout_cnt++;
					r.status = ST_TIMEOUT;
				end else begin
					r.status = ST_WAIT;
					r.wake = deadline;
					if (!gap_ok && gap_end < {1'b0, deadline}) r.wake = gap_end[39:0];
				end
			end
		end
		r.waits = wait_cnt;
		r.timeouts = timeout_cnt;
		r.inflight = inflight_cnt;
	endtask

	assign pending = expected_results.size();

	// predict on every accepted request, compare on every accepted result
	always @(posedge clk or negedge arst_n) begin
		gate_result_t want;
		if (!arst_n) begin
			conc_limit <= 8'd2;
			gap_ms <= 16'd150;
			wait_cnt = '0;
			timeout_cnt = '0;
			inflight_cnt = '0;
			for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
			expected_results.delete();
			errors <= 0;
			granted_seen <= 0;
			waited_seen <= 0;
			timeout_seen <= 0;
			ungated_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_MAX_CONC) conc_limit <= pwdata[7:0];
				else gap_ms <= pwdata[15:0];
			end
			if (req_mon.valid && req_mon.ready) begin
				predict_gate(req_mon.req_type, req_mon.host_key, req_mon.now_ms,
					req_mon.deadline_ms, req_mon.is_retry, want);
				expected_results.push_back(want);
			end
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (expected_results.size() == 0) begin
					if (errors < 10) $display("result with no request pending: status %0d",
						rsp_mon.status);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					case (want.status)
						ST_GRANTED: granted_seen <= granted_seen + 1;
						ST_WAIT: waited_seen <= waited_seen + 1;
						ST_TIMEOUT: timeout_seen <= timeout_seen + 1;
						ST_UNGATED: ungated_seen <= ungated_seen + 1;
						default: ;
					endcase
					if (rsp_mon.status !== want.status || rsp_mon.wake_ms !== want.wake ||
						rsp_mon.waits_total !== want.waits ||
						rsp_mon.timeouts_total !== want.timeouts ||
						rsp_mon.inflight_total !== want.inflight) begin
						if (errors < 10) begin
							$display("mismatch at %0t: status %0d/%0d wake %0h/%0h waits %0d/%0d",
								$realtime, want.status, rsp_mon.status, want.wake,
								rsp_mon.wake_ms, want.waits, rsp_mon.waits_total);
							$display("  timeouts %0d/%0d inflight %0d/%0d (expected/actual)",
								want.timeouts, rsp_mon.timeouts_total, want.inflight,
								rsp_mon.inflight_total);
						end
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

@@ sim/per_host_concurrency_gap_gate_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_host_concurrency_gap_gate_unit_tb
// Drives directed and random acquire/release requests with random idling on
// both channels, several register settings, a long result stall and a run
// that fills the whole slot table; the checker beside the block judges them.
// ----------------------------------------------------------------------------
module per_host_concurrency_gap_gate_unit_tb;
	import phg_pkg::*;

	localparam int CYCLE_LIMIT = 20000000;
	localparam logic [39:0] T_MAX = '1;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	int errors, pending, n_grant, n_wait, n_timeout, n_ungated;
	int send_idle, recv_idle;
	int stall_pending;
	int cycles;
	int sent;
	logic [63:0] host_pool [10];
	logic [39:0] clock_ms;

	phg_req_if req_ch();
	phg_rsp_if rsp_ch();

	per_host_concurrency_gap_gate_unit u_top (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	phg_gate_checker u_chk (
		.clk(clk), .arst_n(arst_n), .req_mon(req_ch), .rsp_mon(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready), .errors(errors), .pending(pending),
		.granted_seen(n_grant), .waited_seen(n_wait), .timeout_seen(n_timeout),
		.ungated_seen(n_ungated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[per_host_concurrency_gap_gate_unit] ERROR");
			$finish;
		end
	end

	// result side, with random idling and an optional long hold-off
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (stall_pending != 0) begin
				stall_pending = 0;
				hold = 400;
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold > 0) begin
				rsp_ch.ready <= 1'b0;
				hold--;
			end else begin
				rsp_ch.ready <= $urandom_range(99) >= recv_idle;
			end
		end
	end

	task automatic send_request(input logic rtype, input logic [63:0] key,
		input logic [39:0] now, input logic [39:0] deadline, input logic retry);
		if ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rtype;
		req_ch.host_key <= key;
		req_ch.now_ms <= now;
		req_ch.deadline_ms <= deadline;
		req_ch.is_retry <= retry;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		req_ch.valid <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// let every expected result arrive, then allow for a long probe walk
	task automatic settle;
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2200) @(posedge clk);
	endtask

	task automatic random_traffic(input int count);
		logic [39:0] now, dl;
		for (int i = 0; i < count; i++) begin
			clock_ms += 40'($urandom_range(0, 120));
			now = clock_ms;
			if ($urandom_range(99) < 5) now = 40'({$urandom, $urandom});
			dl = now + 40'($urandom_range(0, 400));
			if ($urandom_range(99) < 10) dl = now - 40'($urandom_range(0, 50));
			send_request($urandom_range(99) < 40 ? REQ_RELEASE : REQ_ACQUIRE,
				host_pool[$urandom_range(0, 9)], now, dl, 1'($urandom));
		end
	endtask

	initial begin
		logic [63:0] hk;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_ACQUIRE;
		req_ch.host_key = '0;
		req_ch.now_ms = '0;
		req_ch.deadline_ms = '0;
		req_ch.is_retry = 1'b0;
		rsp_ch.ready = 1'b0;
		cycles = 0;
		sent = 0;
		stall_pending = 0;
		send_idle = 15;
		recv_idle = 79;
		clock_ms = 40'd5000;
		host_pool[0] = '0;
		host_pool[1] = '1;
		for (int i = 2; i < 10; i++) host_pool[i] = {$urandom, $urandom};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings of two in flight and 150 ms gap
		send_request(REQ_ACQUIRE, host_pool[0], 40'd1000, 40'd2000, 1'b0);
		send_request(REQ_ACQUIRE, host_pool[0], 40'd1010, 40'd2000, 1'b0);
		send_request(REQ_ACQUIRE, host_pool[0], 40'd1150, 40'd2000, 1'b1);
		send_request(REQ_ACQUIRE, host_pool[0], 40'd1400, 40'd1400, 1'b0);
		send_request(REQ_ACQUIRE, host_pool[0], 40'd1500, 40'd1600, 1'b1);
		send_request(REQ_RELEASE, host_pool[0], 40'd1600, 40'd0, 1'b0);
		send_request(REQ_RELEASE, host_pool[0], 40'd1600, 40'd0, 1'b0);
		// release of an idle host, then of an unknown host
		send_request(REQ_RELEASE, host_pool[0], 40'd1600, 40'd0, 1'b0);
		send_request(REQ_RELEASE, host_pool[1], 40'd1600, 40'd0, 1'b0);
		// top of the time range: ready time runs past 40 bits
		send_request(REQ_ACQUIRE, host_pool[1], T_MAX, T_MAX, 1'b1);
		send_request(REQ_ACQUIRE, host_pool[1], T_MAX, T_MAX, 1'b0);
		send_request(REQ_ACQUIRE, host_pool[1], 40'd0, T_MAX, 1'b0);
		send_request(REQ_ACQUIRE, host_pool[2], 40'd100, 40'd120, 1'b0);
		send_request(REQ_ACQUIRE, host_pool[2], 40'd160, T_MAX, 1'b0);
		settle();
		// gate disabled
		write_reg(REG_MAX_CONC, 32'd0);
		write_reg(REG_MIN_GAP, 32'd0);
		send_request(REQ_ACQUIRE, host_pool[3], 40'd10, 40'd20, 1'b1);
		send_request(REQ_RELEASE, host_pool[3], 40'd10, 40'd20, 1'b0);
		settle();
		// widest settings
		write_reg(REG_MAX_CONC, 32'd255);
		write_reg(REG_MIN_GAP, 32'd65535);
		send_request(REQ_ACQUIRE, host_pool[4], 40'd70000, T_MAX, 1'b0);
		send_request(REQ_ACQUIRE, host_pool[4], 40'd70001, T_MAX, 1'b0);
		send_request(REQ_ACQUIRE, host_pool[4], 40'd135535, T_MAX, 1'b1);
		settle();

		// random phases, each with its own settings; the first three also set the idling
		send_idle = 15;
		recv_idle = 79;
		write_reg(REG_MAX_CONC, 32'd2);
		write_reg(REG_MIN_GAP, 32'd150);
		random_traffic(200);
		settle();
		send_idle = 79;
		recv_idle = 15;
		write_reg(REG_MAX_CONC, 32'd0);
		write_reg(REG_MIN_GAP, 32'd10);
		random_traffic(200);
		settle();
		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_MAX_CONC, 32'd255);
		write_reg(REG_MIN_GAP, 32'd0);
		stall_pending = 1;
		random_traffic(150);
		settle();
		write_reg(REG_MAX_CONC, 32'd1);
		write_reg(REG_MIN_GAP, 32'd65535);
		random_traffic(100);
		settle();
		write_reg(REG_MAX_CONC, 32'd0);
		write_reg(REG_MIN_GAP, 32'd0);
		random_traffic(50);
		settle();

		// fill the slot table with new hosts, then run against a full table
		write_reg(REG_MAX_CONC, 32'd2);
		write_reg(REG_MIN_GAP, 32'd150);
		for (int i = 0; i < 1030; i++) begin
			hk = {$urandom, $urandom};
			send_request(REQ_RELEASE, hk, clock_ms, clock_ms, 1'b0);
		end
		for (int i = 0; i < 40; i++) begin
			hk = ($urandom_range(1) != 0) ? host_pool[$urandom_range(0, 9)] :
				{$urandom, $urandom};
			clock_ms += 40'($urandom_range(0, 200));
			send_request(1'($urandom), hk, clock_ms,
				clock_ms + 40'($urandom_range(0, 300)), 1'($urandom));
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2200) @(posedge clk);
		$display("%0d requests: %0d granted, %0d waits, %0d timeouts, %0d ungated",
			sent, n_grant, n_wait, n_timeout, n_ungated);
		$display("settings swept over limits 0..255 and gaps 0..65535, table filled");
		if (errors == 0 && pending == 0) begin
			$display("[per_host_concurrency_gap_gate_unit] OK");
		end else begin
			$display("[per_host_concurrency_gap_gate_unit] ERROR");
		end
		$finish;
	end
endmodule

@@ per_host_concurrency_gap_gate_unit.f @@
src/phg_pkg.sv
src/phg_if.sv
src/phg_ctrl.sv
src/phg_dp.sv
src/per_host_concurrency_gap_gate_unit.sv
src/phg_checker.sv
sim/phg_gate_checker.sv
sim/per_host_concurrency_gap_gate_unit_tb.sv
